// ----- src/tch_pkg.sv -----
// Package for the tilt-compensated heading core: sizes, CORDIC angle table,
// controller state type and the command/result structs.
// No dependencies.
package tch_pkg;

  localparam int WINDOW_LEN   = 10;
  localparam int CORDIC_STEPS = 16;

  localparam int MAG_W  = 12;
  localparam int ANG_W  = 16;
  localparam int SUM_W  = MAG_W + $clog2(WINDOW_LEN);
  localparam int FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int NUM_W  = SUM_W + 1;
  localparam int DEN_W  = FILL_W + 1;
  localparam int SC_W   = 20;
  localparam int TRIG_W = 18;
  localparam int MA_W   = 31;
  localparam int PROD_W = MA_W + TRIG_W;
  localparam int ACC_W  = 48;
  localparam int CNT_W  = 6;
  localparam int IDX_W  = 5;

  localparam logic [31:0] TURN_HALF    = 32'h8000_0000;
  localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;
  localparam int          CORDIC_START = 9949;

  // product sequence steps of one heading pass
  localparam logic [2:0] PS_LAST = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SC_ROLL,
    ST_SC_PITCH,
    ST_DIV,
    ST_PROD,
    ST_VEC,
    ST_DONE
  } tch_state_t;

  typedef struct packed {
    logic             load;
    logic             sc_init;
    logic             sc_step;
    logic             sc_store;
    logic             sc_pitch;
    logic             div_init;
    logic             div_step;
    logic             div_store;
    logic [1:0]       axis;
    logic             prod_en;
    logic [2:0]       pidx;
    logic             use_avg;
    logic             vec_init;
    logic             vec_step;
    logic             vec_store;
    logic [IDX_W-1:0] idx;
    logic             out_load;
  } tch_cmd_t;

  typedef struct packed {
    logic                    operation;
    logic                    sample_valid;
    logic signed [MAG_W-1:0] mag_x;
    logic signed [MAG_W-1:0] mag_y;
    logic signed [MAG_W-1:0] mag_z;
    logic signed [ANG_W-1:0] roll;
    logic signed [ANG_W-1:0] pitch;
  } tch_in_t;

  typedef struct packed {
    logic                    valid_res;
    logic signed [ANG_W-1:0] heading_filtered;
    logic signed [ANG_W-1:0] heading_raw;
    logic signed [MAG_W-1:0] avg_x;
    logic signed [MAG_W-1:0] avg_y;
    logic signed [MAG_W-1:0] avg_z;
  } tch_res_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_entry(input logic [IDX_W-1:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051D;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2E;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

// ----- src/tilt_compensated_heading_core.sv -----
// Top level of the tilt-compensated heading core: stream ports, input unpack,
// output register. Depends on tch_pkg, tch_ctrl and tch_dp.
//
// channel | dir | ports                              | beat
// in      | in  | in_tvalid/in_tready/in_tdata/tuser | one sample with roll and pitch
// out     | out | out_tvalid/out_tready/out_tdata/tu | one heading and average result
//
// Each item runs two sin/cos CORDIC passes, three bit-serial averaging divisions
// and two product plus atan2 CORDIC passes, one after the other, then hands its
// result to the output register; in_tready is high only while the core is idle,
// so a new item is taken only once the last result has been handed off.
// Synchronous active-low reset clears sums, counters, latched field and the
// reference heading. A result waits in the output register while the next
// item is taken; the core holds its result only if that register is still full.
module tilt_compensated_heading_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // mag_x[11:0], mag_y[23:12], mag_z[35:24], roll[51:36], pitch[67:52], zero fill
  input  logic [71:0] in_tdata,
  // operation[0], sample_valid[1]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // heading_filtered[15:0], heading_raw[31:16], avg_x[43:32], avg_y[55:44],
  // avg_z[67:56], zero fill
  output logic [71:0] out_tdata,
  // valid_res[0]
  output logic [0:0]  out_tuser
);

  tch_pkg::tch_cmd_t cmd;
  tch_pkg::tch_in_t  in_item;
  tch_pkg::tch_res_t res;
  logic              out_free;
  logic              out_valid_r;
  logic [71:0]       out_data_r;
  logic [0:0]        out_user_r;

  // input unpack
  always_comb begin
    in_item.operation    = in_tuser[0];
    in_item.sample_valid = in_tuser[1];
    in_item.mag_x        = $signed(in_tdata[11:0]);
    in_item.mag_y        = $signed(in_tdata[23:12]);
    in_item.mag_z        = $signed(in_tdata[35:24]);
    in_item.roll         = $signed(in_tdata[51:36]);
    in_item.pitch        = $signed(in_tdata[67:52]);
  end

  assign out_free = !out_valid_r || out_tready;

  tch_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_free (out_free),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  tch_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_item (in_item),
    .res     (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {4'h0, res.avg_z, res.avg_y, res.avg_x,
                     res.heading_raw, res.heading_filtered};
      out_user_r <= res.valid_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ----- src/tch_ctrl.sv -----
// Controller for the heading core: sequences sin/cos, averaging division,
// tilt products and atan2 CORDIC passes. Depends on tch_pkg.
module tch_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_free,
  output logic              in_ready,
  output tch_pkg::tch_cmd_t cmd
);

  tch_pkg::tch_state_t state_r, state_nxt;
  logic [tch_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic       pass_r, pass_nxt;

  localparam logic [tch_pkg::CNT_W-1:0] SC_END  = tch_pkg::CNT_W'(tch_pkg::CORDIC_STEPS + 1);
  localparam logic [tch_pkg::CNT_W-1:0] DIV_END = tch_pkg::CNT_W'(tch_pkg::NUM_W + 1);
  localparam logic [tch_pkg::CNT_W-1:0] PS_END  = tch_pkg::CNT_W'(tch_pkg::PS_LAST);

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tch_pkg::ST_IDLE;
      cnt_r   <= '0;
      axis_r  <= '0;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      axis_r  <= axis_nxt;
      pass_r  <= pass_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 1'b1;
    axis_nxt  = axis_r;
    pass_nxt  = pass_r;
    unique case (state_r)
      tch_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          state_nxt = tch_pkg::ST_SC_ROLL;
        end
      end
      tch_pkg::ST_SC_ROLL: begin
        if (cnt_r == SC_END) begin
          state_nxt = tch_pkg::ST_SC_PITCH;
          cnt_nxt   = '0;
        end
      end
      tch_pkg::ST_SC_PITCH: begin
        if (cnt_r == SC_END) begin
          state_nxt = tch_pkg::ST_DIV;
          cnt_nxt   = '0;
          axis_nxt  = '0;
        end
      end
      tch_pkg::ST_DIV: begin
        if (cnt_r == DIV_END) begin
          cnt_nxt = '0;
          if (axis_r == 2'd2) begin
            state_nxt = tch_pkg::ST_PROD;
            pass_nxt  = 1'b0;
          end else begin
            axis_nxt = axis_r + 1'b1;
          end
        end
      end
      tch_pkg::ST_PROD: begin
        if (cnt_r == PS_END) begin
          state_nxt = tch_pkg::ST_VEC;
          cnt_nxt   = '0;
        end
      end
      tch_pkg::ST_VEC: begin
        if (cnt_r == SC_END) begin
          cnt_nxt = '0;
          if (pass_r) begin
            state_nxt = tch_pkg::ST_DONE;
          end else begin
            state_nxt = tch_pkg::ST_PROD;
            pass_nxt  = 1'b1;
          end
        end
      end
      tch_pkg::ST_DONE: begin
        cnt_nxt = '0;
        if (out_free) begin
          state_nxt = tch_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tch_pkg::ST_IDLE;
      end
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    cmd.axis = axis_r;
    cmd.pidx = cnt_r[2:0];
    cmd.idx  = tch_pkg::IDX_W'(cnt_r - 1'b1);
    cmd.use_avg = pass_r;
    in_ready = 1'b0;
    unique case (state_r)
      tch_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      tch_pkg::ST_SC_ROLL, tch_pkg::ST_SC_PITCH: begin
        cmd.sc_pitch = (state_r == tch_pkg::ST_SC_PITCH);
        cmd.sc_init  = (cnt_r == '0);
        cmd.sc_store = (cnt_r == SC_END);
        cmd.sc_step  = !cmd.sc_init && !cmd.sc_store;
      end
      tch_pkg::ST_DIV: begin
        cmd.div_init  = (cnt_r == '0);
        cmd.div_store = (cnt_r == DIV_END);
        cmd.div_step  = !cmd.div_init && !cmd.div_store;
      end
      tch_pkg::ST_PROD: begin
        cmd.prod_en = 1'b1;
      end
      tch_pkg::ST_VEC: begin
        cmd.vec_init  = (cnt_r == '0);
        cmd.vec_store = (cnt_r == SC_END);
        cmd.vec_step  = !cmd.vec_init && !cmd.vec_store;
      end
      tch_pkg::ST_DONE: begin
        cmd.out_load = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- src/tch_dp.sv -----
// Datapath for the heading core: sample windows and sums, shared sin/cos
// CORDIC, restoring divider, product unit and atan2 CORDIC. Depends on tch_pkg.
module tch_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  tch_pkg::tch_cmd_t cmd,
  input  tch_pkg::tch_in_t  in_item,
  output tch_pkg::tch_res_t res
);

  localparam int MAG_W = tch_pkg::MAG_W;
  localparam int SUM_W = tch_pkg::SUM_W;
  localparam int ACC_W = tch_pkg::ACC_W;

  // ---------------- item registers ----------------
  logic recal_r;
  logic signed [tch_pkg::ANG_W-1:0] roll_r, pitch_r;

  // ---------------- window state ----------------
  logic signed [MAG_W-1:0] winx_r [tch_pkg::WINDOW_LEN];
  logic signed [MAG_W-1:0] winy_r [tch_pkg::WINDOW_LEN];
  logic signed [MAG_W-1:0] winz_r [tch_pkg::WINDOW_LEN];
  logic signed [SUM_W-1:0] sumx_r, sumy_r, sumz_r, sumx_nxt, sumy_nxt, sumz_nxt;
  logic [tch_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic [tch_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic signed [MAG_W-1:0] lat_r [3];
  logic last_valid_r;
  logic [tch_pkg::ANG_W-1:0] ref_r;
  logic full;
  logic [tch_pkg::FILL_W-1:0] fill_base;
  logic [tch_pkg::SLOT_W-1:0] slot_base;
  logic signed [SUM_W-1:0] bx, by, bz;

  // window push on an accepted valid sample; a recalibrate empties it first
  always_comb begin
    fill_base = cmd.load && in_item.operation ? '0 : fill_r;
    slot_base = cmd.load && in_item.operation ? '0 : slot_r;
    bx = cmd.load && in_item.operation ? '0 : sumx_r;
    by = cmd.load && in_item.operation ? '0 : sumy_r;
    bz = cmd.load && in_item.operation ? '0 : sumz_r;
    full = (fill_base == tch_pkg::FILL_W'(tch_pkg::WINDOW_LEN));
    sumx_nxt = bx;
    sumy_nxt = by;
    sumz_nxt = bz;
    fill_nxt = fill_base;
    slot_nxt = slot_base;
    if (in_item.sample_valid) begin
      if (full) begin
        sumx_nxt = bx - SUM_W'(winx_r[slot_base]);
        sumy_nxt = by - SUM_W'(winy_r[slot_base]);
        sumz_nxt = bz - SUM_W'(winz_r[slot_base]);
      end else begin
        fill_nxt = fill_base + 1'b1;
      end
      sumx_nxt = sumx_nxt + SUM_W'(in_item.mag_x);
      sumy_nxt = sumy_nxt + SUM_W'(in_item.mag_y);
      sumz_nxt = sumz_nxt + SUM_W'(in_item.mag_z);
      slot_nxt = (slot_base == tch_pkg::SLOT_W'(tch_pkg::WINDOW_LEN - 1)) ? '0
                 : slot_base + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sumx_r       <= '0;
      sumy_r       <= '0;
      sumz_r       <= '0;
      fill_r       <= '0;
      slot_r       <= '0;
      lat_r[0]     <= '0;
      lat_r[1]     <= '0;
      lat_r[2]     <= '0;
      last_valid_r <= 1'b0;
      recal_r      <= 1'b0;
    end else if (cmd.load) begin
      sumx_r       <= sumx_nxt;
      sumy_r       <= sumy_nxt;
      sumz_r       <= sumz_nxt;
      fill_r       <= fill_nxt;
      slot_r       <= slot_nxt;
      last_valid_r <= in_item.sample_valid;
      recal_r      <= in_item.operation;
      if (in_item.sample_valid) begin
        lat_r[0] <= in_item.mag_x;
        lat_r[1] <= in_item.mag_y;
        lat_r[2] <= in_item.mag_z;
      end
    end
  end

  // window memories, no reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      roll_r  <= in_item.roll;
      pitch_r <= in_item.pitch;
      if (in_item.sample_valid) begin
        winx_r[slot_base] <= in_item.mag_x;
        winy_r[slot_base] <= in_item.mag_y;
        winz_r[slot_base] <= in_item.mag_z;
      end
    end
  end

  // ---------------- sin/cos rotation CORDIC ----------------
  logic signed [tch_pkg::SC_W-1:0] scx_r, scy_r;
  logic signed [32:0] scz_r;
  logic sflip_r;
  logic signed [tch_pkg::TRIG_W-1:0] sr_r, cr_r, sp_r, cp_r;
  logic [31:0] ang, ang_f, atan_v;
  logic        fold;
  logic signed [tch_pkg::SC_W-1:0] sdx, sdy, sx_o, sy_o;

  assign atan_v = tch_pkg::atan_entry(cmd.idx);

  always_comb begin
    ang   = {(cmd.sc_pitch ? pitch_r : roll_r), 16'h0000};
    fold  = (ang - tch_pkg::TURN_QUARTER) < tch_pkg::TURN_HALF;
    ang_f = fold ? ang + tch_pkg::TURN_HALF : ang;
    sdx   = scy_r >>> cmd.idx;
    sdy   = scx_r >>> cmd.idx;
    sx_o  = sflip_r ? -scx_r : scx_r;
    sy_o  = sflip_r ? -scy_r : scy_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.sc_init) begin
      scx_r   <= tch_pkg::SC_W'(tch_pkg::CORDIC_START);
      scy_r   <= '0;
      scz_r   <= {ang_f[31], ang_f};
      sflip_r <= fold;
    end else if (cmd.sc_step) begin
      if (!scz_r[32]) begin
        scx_r <= scx_r - sdx;
        scy_r <= scy_r + sdy;
        scz_r <= scz_r - $signed({1'b0, atan_v});
      end else begin
        scx_r <= scx_r + sdx;
        scy_r <= scy_r - sdy;
        scz_r <= scz_r + $signed({1'b0, atan_v});
      end
    end
    if (cmd.sc_store) begin
      if (cmd.sc_pitch) begin
        cp_r <= tch_pkg::TRIG_W'(sx_o);
        sp_r <= tch_pkg::TRIG_W'(sy_o);
      end else begin
        cr_r <= tch_pkg::TRIG_W'(sx_o);
        sr_r <= tch_pkg::TRIG_W'(sy_o);
      end
    end
  end

  // ---------------- window average divider ----------------
  logic signed [SUM_W-1:0] dsum;
  logic [SUM_W-1:0] dmag;
  logic [tch_pkg::NUM_W-1:0] dnum_r, dquo_r;
  logic [tch_pkg::DEN_W-1:0] drem_r, dden;
  logic [tch_pkg::DEN_W:0]   dtrial;
  logic dneg_r, dge;
  logic signed [MAG_W:0] dq_s;
  logic signed [MAG_W-1:0] avg_r [3];

  always_comb begin
    unique case (cmd.axis)
      2'd0:    dsum = sumx_r;
      2'd1:    dsum = sumy_r;
      default: dsum = sumz_r;
    endcase
    dmag   = dsum[SUM_W-1] ? (~dsum + 1'b1) : dsum;
    dden   = {fill_r, 1'b0};
    dtrial = {drem_r, dnum_r[tch_pkg::NUM_W-1]};
    dge    = dtrial >= {1'b0, dden};
    dq_s   = $signed(dquo_r[MAG_W:0]);
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dnum_r <= {dmag, 1'b0} + tch_pkg::NUM_W'(fill_r);
      drem_r <= '0;
      dquo_r <= '0;
      dneg_r <= dsum[SUM_W-1];
    end else if (cmd.div_step) begin
      dnum_r <= dnum_r << 1;
      dquo_r <= {dquo_r[tch_pkg::NUM_W-2:0], dge};
      drem_r <= dge ? tch_pkg::DEN_W'(dtrial - {1'b0, dden}) : tch_pkg::DEN_W'(dtrial);
    end
    if (cmd.div_store) begin
      if (fill_r == '0) begin
        avg_r[cmd.axis] <= '0;
      end else begin
        avg_r[cmd.axis] <= MAG_W'(dneg_r ? -dq_s : dq_s);
      end
    end
  end

  // ---------------- tilt product unit ----------------
  logic signed [MAG_W-1:0] m0, m1, m2;
  logic signed [tch_pkg::MA_W-1:0] ma;
  logic signed [tch_pkg::TRIG_W-1:0] mb;
  logic signed [tch_pkg::PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0] accx_r, accy_r, pext;

  always_comb begin
    m0   = cmd.use_avg ? avg_r[0] : lat_r[0];
    m1   = cmd.use_avg ? avg_r[1] : lat_r[1];
    m2   = cmd.use_avg ? avg_r[2] : lat_r[2];
    pext = ACC_W'(prod_r);
    unique case (cmd.pidx)
      3'd0:    begin ma = tch_pkg::MA_W'(m2); mb = sr_r; end
      3'd1:    begin ma = tch_pkg::MA_W'(m1); mb = cr_r; end
      3'd2:    begin ma = tch_pkg::MA_W'(m0); mb = cp_r; end
      3'd3:    begin ma = tch_pkg::MA_W'(m1); mb = sp_r; end
      3'd4:    begin ma = tch_pkg::MA_W'(prod_r); mb = sr_r; end
      3'd5:    begin ma = tch_pkg::MA_W'(m2); mb = sp_r; end
      3'd6:    begin ma = tch_pkg::MA_W'(prod_r); mb = cr_r; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // yh = (m2*sr - m1*cr) << 14, xh = m0*cp << 14 + m1*sp*sr + m2*sp*cr
  always_ff @(posedge clk) begin
    if (cmd.prod_en) begin
      prod_r <= ma * mb;
      unique case (cmd.pidx)
        3'd1:    accy_r <= pext;
        3'd2:    accy_r <= accy_r - pext;
        3'd3:    accx_r <= pext <<< 14;
        3'd5:    accx_r <= accx_r + pext;
        3'd7:    begin
          accx_r <= accx_r + pext;
          accy_r <= accy_r <<< 14;
        end
        default: accx_r <= accx_r;
      endcase
    end
  end

  // ---------------- atan2 vectoring CORDIC ----------------
  logic signed [ACC_W-1:0] vx_r, vy_r, vdx, vdy;
  logic [31:0] vz_r, vsum;
  logic vzero_r;
  logic [tch_pkg::ANG_W-1:0] hraw_r, hfilt_r, vhead;

  always_comb begin
    vdx   = vy_r >>> cmd.idx;
    vdy   = vx_r >>> cmd.idx;
    vsum  = (vzero_r ? 32'h0 : vz_r) + 32'h0000_8000;
    vhead = vsum[31:16];
  end

  always_ff @(posedge clk) begin
    if (cmd.vec_init) begin
      vzero_r <= (accx_r == '0) && (accy_r == '0);
      if (accx_r[ACC_W-1]) begin
        vx_r <= -accx_r;
        vy_r <= -accy_r;
        vz_r <= tch_pkg::TURN_HALF;
      end else begin
        vx_r <= accx_r;
        vy_r <= accy_r;
        vz_r <= '0;
      end
    end else if (cmd.vec_step) begin
      if (vy_r[ACC_W-1]) begin
        vx_r <= vx_r - vdx;
        vy_r <= vy_r + vdy;
        vz_r <= vz_r - atan_v;
      end else begin
        vx_r <= vx_r + vdx;
        vy_r <= vy_r - vdy;
        vz_r <= vz_r + atan_v;
      end
    end
    if (cmd.vec_store) begin
      if (cmd.use_avg) begin
        hfilt_r <= vhead;
      end else begin
        hraw_r <= vhead;
      end
    end
  end

  // reference heading: cleared by reset, replaced by the raw heading on recalibrate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= '0;
    end else if (cmd.vec_store && !cmd.use_avg && recal_r) begin
      ref_r <= vhead;
    end
  end

  // result fields
  always_comb begin
    res.valid_res        = last_valid_r;
    res.heading_filtered = $signed(hfilt_r - ref_r);
    res.heading_raw      = $signed(hraw_r - ref_r);
    res.avg_x            = avg_r[0];
    res.avg_y            = avg_r[1];
    res.avg_z            = avg_r[2];
  end

endmodule

// ----- test/tch_tb_pkg.sv -----
// Shared codes for the heading core testbench: operation and flag bits of in_tuser.
// Depends on nothing.
`timescale 1ns / 1ps
package tch_tb_pkg;

  localparam logic OP_NORMAL = 1'b0;
  localparam logic OP_RECAL  = 1'b1;

  // bit positions inside in_tuser
  localparam int USER_OP    = 0;
  localparam int USER_VALID = 1;

endpackage

// ----- test/tch_heading_checker.sv -----
// Checker for the heading core: predicts each result from accepted input beats
// and compares it with the output stream. Depends on tch_pkg and tch_tb_pkg.
`timescale 1ns / 1ps
module tch_heading_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,
  input  logic [0:0]  out_tuser,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  localparam logic [31:0] ATAN_TURN [24] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  // predictor state, all zero after reset
  int          win [3][tch_pkg::WINDOW_LEN];
  int          win_sum [3];
  int          fill, slot;
  int          held_mag [3];
  logic [15:0] ref_heading = '0;

  tch_pkg::tch_res_t heading_q [$];

  // rotation-mode CORDIC, Q14 sin and cos
  function automatic void rotate_sin_cos(input logic [31:0] ang,
                                         output longint s, output longint c);
    logic [31:0] a;
    bit          flip;
    longint      x, y, z, dx, dy;
    a = ang;
    flip = 0;
    if ((a - tch_pkg::TURN_QUARTER) < tch_pkg::TURN_HALF) begin
      a = a + tch_pkg::TURN_HALF;
      flip = 1;
    end
    z = longint'($signed(a));
    x = tch_pkg::CORDIC_START;
    y = 0;
    for (int i = 0; i < tch_pkg::CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TURN[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TURN[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endfunction

  // vectoring-mode CORDIC, angle in 2^-32 turn
  function automatic logic [31:0] vector_angle(input longint yi, input longint xi);
    longint      x, y, dx, dy;
    logic [31:0] z;
    x = xi;
    y = yi;
    z = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x; y = -y; z = tch_pkg::TURN_HALF;
    end
    for (int i = 0; i < tch_pkg::CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x -= dx; y += dy; z = z - ATAN_TURN[i];
      end else begin
        x += dx; y -= dy; z = z + ATAN_TURN[i];
      end
    end
    return z;
  endfunction

  function automatic logic [15:0] tilt_heading(input int mx, input int my, input int mz,
                                               input longint sr, input longint cr,
                                               input longint sp, input longint cp);
    longint      yh, xh;
    logic [31:0] t;
    yh = (longint'(mz) * sr - longint'(my) * cr) * 16384;
    xh = longint'(mx) * cp * 16384 + longint'(my) * sp * sr + longint'(mz) * sp * cr;
    t = vector_angle(yh, xh) + 32'h8000;
    return t[31:16];
  endfunction

  // mean rounded to nearest, ties away from zero
  function automatic int window_mean(input int total, input int count);
    longint m, q;
    if (count == 0) return 0;
    m = (total < 0) ? -longint'(total) : longint'(total);
    q = (2 * m + count) / (2 * longint'(count));
    return (total < 0) ? int'(-q) : int'(q);
  endfunction

  function automatic void clear_windows();
    win_sum = '{0, 0, 0};
    fill = 0;
    slot = 0;
  endfunction

  task automatic predict_beat(input logic [71:0] d, input logic [1:0] u);
    longint            sr, cr, sp, cp;
    int                mean [3];
    int                k;
    logic              recal, valid;
    tch_pkg::tch_res_t r;
    recal = (u[tch_tb_pkg::USER_OP] == tch_tb_pkg::OP_RECAL);
    valid = u[tch_tb_pkg::USER_VALID];
    rotate_sin_cos({d[51:36], 16'h0}, sr, cr);
    rotate_sin_cos({d[67:52], 16'h0}, sp, cp);
    if (recal) begin
      clear_windows();
      ref_heading = '0;
    end
    if (valid) begin
      held_mag[0] = $signed(d[11:0]);
      held_mag[1] = $signed(d[23:12]);
      held_mag[2] = $signed(d[35:24]);
      k = slot;
      for (int a = 0; a < 3; a++) begin
        if (fill >= tch_pkg::WINDOW_LEN) win_sum[a] -= win[a][k];
        win[a][k] = held_mag[a];
        win_sum[a] += held_mag[a];
      end
      if (fill < tch_pkg::WINDOW_LEN) fill++;
      slot = (k + 1 >= tch_pkg::WINDOW_LEN) ? 0 : k + 1;
    end
    if (recal)
      ref_heading = tilt_heading(held_mag[0], held_mag[1], held_mag[2], sr, cr, sp, cp);
    for (int a = 0; a < 3; a++) mean[a] = window_mean(win_sum[a], fill);
    r.valid_res        = valid;
    r.heading_filtered = tilt_heading(mean[0], mean[1], mean[2], sr, cr, sp, cp)
                         - ref_heading;
    r.heading_raw      = tilt_heading(held_mag[0], held_mag[1], held_mag[2],
                                      sr, cr, sp, cp) - ref_heading;
    r.avg_x = mean[0][11:0];
    r.avg_y = mean[1][11:0];
    r.avg_z = mean[2][11:0];
    heading_q.push_back(r);
  endtask

  task automatic report(input string field, input logic [15:0] exp_v, input logic [15:0] act_v);
    $display("%0t: mismatch on %s: expected %h, got %h", $time, field, exp_v, act_v);
    fail_count++;
  endtask

  assign pending = heading_q.size();

  // sample both channels at the clock edge
  always @(posedge clk) begin
    tch_pkg::tch_res_t e;
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_beat(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        if (heading_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, out_tdata);
          fail_count++;
        end else begin
          e = heading_q.pop_front();
          checked++;
          if (out_tuser[0] !== e.valid_res)
            report("valid_res", 16'(e.valid_res), 16'(out_tuser[0]));
          if (out_tdata[15:0] !== e.heading_filtered)
            report("heading_filtered", e.heading_filtered, out_tdata[15:0]);
          if (out_tdata[31:16] !== e.heading_raw)
            report("heading_raw", e.heading_raw, out_tdata[31:16]);
          if (out_tdata[43:32] !== e.avg_x)
            report("avg_x", 16'(e.avg_x), 16'(out_tdata[43:32]));
          if (out_tdata[55:44] !== e.avg_y)
            report("avg_y", 16'(e.avg_y), 16'(out_tdata[55:44]));
          if (out_tdata[67:56] !== e.avg_z)
            report("avg_z", 16'(e.avg_z), 16'(out_tdata[67:56]));
          if (out_tdata[71:68] !== 4'h0)
            report("zero fill", 16'h0, 16'(out_tdata[71:68]));
        end
      end
    end
  end

endmodule

// ----- test/tilt_compensated_heading_core_tb.sv -----
// Testbench top for the heading core: clock, reset, stimulus and verdict.
// Depends on tch_tb_pkg, tch_heading_checker and the core RTL.
`timescale 1ns / 1ps
module tilt_compensated_heading_core_tb;

  localparam int RANDOM_ITEMS = 1130;
  localparam int CYCLE_LIMIT  = 1000000;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready;
  logic [71:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [0:0]  out_tuser;
  int          fail_count, pending, checked;
  int          cycles, beats_sent;
  bit          no_idle;

  tilt_compensated_heading_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  tch_heading_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .fail_count(fail_count), .pending(pending), .checked(checked)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // random receiver stalls
  always @(posedge clk)
    out_tready <= no_idle || ($urandom_range(99) >= 33);

  task automatic send_beat(input logic op, input logic valid, input logic [11:0] mx,
                           input logic [11:0] my, input logic [11:0] mz,
                           input logic [15:0] roll, input logic [15:0] pitch);
    while (!no_idle && $urandom_range(99) < 33) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'h0, pitch, roll, mz, my, mx};
    in_tuser  <= {valid, op};
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  task automatic send_random(input int n);
    logic op, valid;
    int   r;
    r = $urandom_range(99);
    op = (r < 6) ? tch_tb_pkg::OP_RECAL : tch_tb_pkg::OP_NORMAL;
    valid = ($urandom_range(99) >= 15);
    // small-field and full-range mixes
    if (n % 4 == 0)
      send_beat(op, valid, 12'($urandom_range(15) - 8), 12'($urandom_range(15) - 8),
                12'($urandom_range(15) - 8), 16'($urandom), 16'($urandom));
    else
      send_beat(op, valid, 12'($urandom), 12'($urandom), 12'($urandom),
                16'($urandom), 16'($urandom));
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    beats_sent = 0;
    no_idle    = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: recal on empty state, extremes, zero field, invalid samples
    send_beat(tch_tb_pkg::OP_RECAL,  1'b0, 12'h000, 12'h000, 12'h000, 16'h0000, 16'h0000);
    send_beat(tch_tb_pkg::OP_NORMAL, 1'b1, 12'h000, 12'h000, 12'h000, 16'h0000, 16'h0000);
    send_beat(tch_tb_pkg::OP_NORMAL, 1'b1, 12'h7FF, 12'h7FF, 12'h7FF, 16'h7FFF, 16'h7FFF);
    send_beat(tch_tb_pkg::OP_NORMAL, 1'b1, 12'h800, 12'h800, 12'h800, 16'h8000, 16'h8000);
    send_beat(tch_tb_pkg::OP_NORMAL, 1'b1, 12'h7FF, 12'h800, 12'h001, 16'h4000, 16'hC000);
    send_beat(tch_tb_pkg::OP_NORMAL, 1'b1, 12'h800, 12'h7FF, 12'hFFF, 16'hC000, 16'h4000);
    send_beat(tch_tb_pkg::OP_NORMAL, 1'b0, 12'h123, 12'h456, 12'h789, 16'h2000, 16'hE000);
    send_beat(tch_tb_pkg::OP_NORMAL, 1'b1, 12'hF00, 12'h000, 12'h000, 16'h0000, 16'h0000);
    send_beat(tch_tb_pkg::OP_NORMAL, 1'b1, 12'h000, 12'h100, 12'h000, 16'h3FFF, 16'h4001);
    send_beat(tch_tb_pkg::OP_RECAL,  1'b1, 12'h200, 12'hE00, 12'h100, 16'h1000, 16'hF000);
    send_beat(tch_tb_pkg::OP_NORMAL, 1'b1, 12'h201, 12'hE01, 12'h0FF, 16'h1000, 16'hF000);
    send_beat(tch_tb_pkg::OP_RECAL,  1'b0, 12'h555, 12'hAAA, 12'h555, 16'h8001, 16'h7FFE);
    send_beat(tch_tb_pkg::OP_NORMAL, 1'b0, 12'hAAA, 12'h555, 12'hAAA, 16'hFFFF, 16'h0001);
    for (int i = 0; i < 12; i++)
      send_beat(tch_tb_pkg::OP_NORMAL, 1'b1, 12'(i * 300 - 1800), 12'(i * 13 - 70),
                12'(-i), 16'(i * 5461), 16'(-i * 3000));

    // random part, one stretch with no idling
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 400 && n < 560);
      send_random(n);
    end
    no_idle = 0;
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Sent %0d input beats (directed extremes, recalibration, invalid samples,",
             beats_sent);
    $display("random fields with stalls on both sides); %0d results compared.", checked);
    if (fail_count == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
src/tch_pkg.sv
src/tch_ctrl.sv
src/tch_dp.sv
src/tilt_compensated_heading_core.sv
test/tch_tb_pkg.sv
test/tch_heading_checker.sv
test/tilt_compensated_heading_core_tb.sv
